/* src/asgr_pkg.sv */
`timescale 1ns / 1ps

package asgr_pkg;

   // sequence buffer sizing
   localparam int MAX_SEQ   = 32;
   localparam int SEQ_IDX_W = $clog2(MAX_SEQ);
   localparam int SEQ_CNT_W = $clog2(MAX_SEQ + 1);

   localparam int BYTE_W = 8;
   localparam int RGB_W  = 24;

   // command queue between parser and emitter
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_PARSE_ENABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_FG   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_BG   = 2'd2;

   // register reset values
   localparam logic [RGB_W-1:0] RESET_FG = 24'hDCDCDC;
   localparam logic [RGB_W-1:0] RESET_BG = 24'h1E1E1E;

   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic              chunk_end;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic [RGB_W-1:0]  fg_rgb;
      logic [RGB_W-1:0]  bg_rgb;
      logic              bold_on;
      logic              last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [RGB_W-1:0] fg;
      logic [RGB_W-1:0] bg;
      logic             bold;
   } attr_type;

   // one parsed input byte: buffer write, flush before, literal, flush after
   typedef struct packed {
      attr_type             attr;
      logic                 store_en;
      logic [SEQ_IDX_W-1:0] store_idx;
      logic [BYTE_W-1:0]    data_byte;
      logic [SEQ_CNT_W-1:0] pre_count;
      logic                 lit_en;
      logic [SEQ_CNT_W-1:0] post_count;
   } cmd_type;

endpackage

/* src/asgr_front.sv */
`timescale 1ns / 1ps

module asgr_front import asgr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_idx,
   input  logic [RGB_W-1:0]     csr_wdata,
   input  logic                 q_full,
   output logic                 q_push,
   output cmd_type              q_cmd
);

   typedef enum logic [1:0] {
      M_IDLE = 2'd0,
      M_ESC  = 2'd1,
      M_CSI  = 2'd2
   } mode_type;

   localparam logic [BYTE_W-1:0] CH_ESC    = 8'h1B;
   localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
   localparam logic [BYTE_W-1:0] CH_SEMI   = 8'h3B;
   localparam logic [BYTE_W-1:0] CH_M      = 8'h6D;
   localparam logic [BYTE_W-1:0] CH_0      = 8'h30;
   localparam logic [BYTE_W-1:0] CH_9      = 8'h39;
   localparam logic [BYTE_W-1:0] CH_UP_A   = 8'h41;
   localparam logic [BYTE_W-1:0] CH_UP_Z   = 8'h5A;
   localparam logic [BYTE_W-1:0] CH_LO_A   = 8'h61;
   localparam logic [BYTE_W-1:0] CH_LO_Z   = 8'h7A;

   // parameter flag bits
   localparam int PF_NONEMPTY = 0;
   localparam int PF_BAD      = 1;
   localparam int PF_ZERO     = 2;
   localparam int PF_FIRST    = 3;

   localparam logic [BYTE_W-1:0] PV_MAX = 8'd255;

   function automatic logic [RGB_W-1:0] palette(input logic [3:0] idx);
      logic [RGB_W-1:0] c;
      case (idx)
         4'd0:    c = 24'h000000;
         4'd1:    c = 24'hAA0000;
         4'd2:    c = 24'h00AA00;
         4'd3:    c = 24'hAA5500;
         4'd4:    c = 24'h0000AA;
         4'd5:    c = 24'hAA00AA;
         4'd6:    c = 24'h00AAAA;
         4'd7:    c = 24'hAAAAAA;
         4'd8:    c = 24'h555555;
         4'd9:    c = 24'hFF5555;
         4'd10:   c = 24'h55FF55;
         4'd11:   c = 24'hFFFF55;
         4'd12:   c = 24'h5555FF;
         4'd13:   c = 24'hFF55FF;
         4'd14:   c = 24'h55FFFF;
         4'd15:   c = 24'hFFFFFF;
         default: c = 24'h000000;
      endcase
      return c;
   endfunction

   // one sgr code applied to the tentative attributes
   function automatic attr_type apply_code(input logic [BYTE_W-1:0] code,
                                           input attr_type a);
      attr_type          r;
      logic [BYTE_W-1:0] off30;
      logic [BYTE_W-1:0] off40;
      logic [BYTE_W-1:0] off90;
      logic [BYTE_W-1:0] off100;
      r      = a;
      off30  = code - 8'd30;
      off40  = code - 8'd40;
      off90  = code - 8'd90;
      off100 = code - 8'd100;
      if (code == 8'd1) begin
         r.bold = 1'b1;
      end else if (code == 8'd22) begin
         r.bold = 1'b0;
      end else if (code >= 8'd30 && code <= 8'd37) begin
         r.fg = palette({1'b0, off30[2:0]});
      end else if (code >= 8'd40 && code <= 8'd47) begin
         r.bg = palette({1'b0, off40[2:0]});
      end else if (code >= 8'd90 && code <= 8'd97) begin
         r.fg = palette({1'b1, off90[2:0]});
      end else if (code >= 8'd100 && code <= 8'd107) begin
         r.bg = palette({1'b1, off100[2:0]});
      end
      return r;
   endfunction

   // configuration and parser state
   logic                 en_ff, en_in;
   logic [RGB_W-1:0]     dfg_ff, dfg_in;
   logic [RGB_W-1:0]     dbg_ff, dbg_in;
   mode_type             mode_ff, mode_in;
   logic [SEQ_CNT_W-1:0] cnt_ff, cnt_in;
   logic [BYTE_W-1:0]    pv_ff, pv_in;
   logic [3:0]           pf_ff, pf_in;
   attr_type             shadow_ff, shadow_in;
   attr_type             cur_ff, cur_in;

   logic              acc;
   logic [BYTE_W-1:0] b;
   logic              is_letter;
   logic              is_digit;
   logic              ep_valid;
   attr_type          ep_shadow;
   logic [11:0]       pv_acc;
   logic              idle_byte;
   cmd_type           cmd;

   assign req_stall = q_full;
   assign acc       = req_valid && !req_stall;
   assign b         = req_data.in_byte;
   assign is_letter = (b >= CH_UP_A && b <= CH_UP_Z) || (b >= CH_LO_A && b <= CH_LO_Z);
   assign is_digit  = (b >= CH_0 && b <= CH_9);

   // end of a parameter: apply it if it is valid and the sequence is not a reset
   assign ep_valid  = pf_ff[PF_NONEMPTY] && !pf_ff[PF_BAD];
   assign ep_shadow = (!pf_ff[PF_ZERO] && ep_valid) ? apply_code(pv_ff, shadow_ff) : shadow_ff;

   // decimal accumulate, saturating
   assign pv_acc = {1'b0, pv_ff, 3'b000} + {3'b000, pv_ff, 1'b0} + {8'd0, b[3:0]};

   // classify the byte into one command
   always_comb begin
      mode_in   = mode_ff;
      cnt_in    = cnt_ff;
      pv_in     = pv_ff;
      pf_in     = pf_ff;
      shadow_in = shadow_ff;
      cur_in    = cur_ff;
      idle_byte = 1'b0;
      cmd           = '0;
      cmd.attr      = cur_ff;
      cmd.data_byte = b;
      if (!en_ff) begin
         cmd.pre_count = cnt_ff;
         cmd.lit_en    = 1'b1;
         mode_in       = M_IDLE;
         cnt_in        = '0;
         pv_in         = '0;
         pf_in         = '0;
      end else begin
         case (mode_ff)
            M_ESC: begin
               if (b == CH_LBRACK && cnt_ff < SEQ_CNT_W'(MAX_SEQ)) begin
                  cmd.store_en  = 1'b1;
                  cmd.store_idx = cnt_ff[SEQ_IDX_W-1:0];
                  cnt_in        = cnt_ff + SEQ_CNT_W'(1);
                  mode_in       = M_CSI;
                  shadow_in     = cur_ff;
                  pv_in         = '0;
                  pf_in         = 4'b0001 << PF_FIRST;
               end else begin
                  cmd.pre_count = cnt_ff;
                  mode_in       = M_IDLE;
                  cnt_in        = '0;
                  pv_in         = '0;
                  pf_in         = '0;
                  idle_byte     = 1'b1;
               end
            end
            M_CSI: begin
               if (is_letter) begin
                  if (b == CH_M) begin
                     if (pf_ff[PF_ZERO]) begin
                        cur_in.fg   = dfg_ff;
                        cur_in.bg   = dbg_ff;
                        cur_in.bold = 1'b0;
                     end else begin
                        cur_in = ep_shadow;
                     end
                  end
                  shadow_in = ep_shadow;
                  mode_in   = M_IDLE;
                  cnt_in    = '0;
                  pv_in     = '0;
                  pf_in     = '0;
               end else if (cnt_ff >= SEQ_CNT_W'(MAX_SEQ)) begin
                  // buffer full: spill it and start over
                  cmd.pre_count = cnt_ff;
                  mode_in       = M_IDLE;
                  cnt_in        = '0;
                  pv_in         = '0;
                  pf_in         = '0;
                  idle_byte     = 1'b1;
               end else begin
                  cmd.store_en  = 1'b1;
                  cmd.store_idx = cnt_ff[SEQ_IDX_W-1:0];
                  cnt_in        = cnt_ff + SEQ_CNT_W'(1);
                  if (b == CH_SEMI) begin
                     shadow_in      = ep_shadow;
                     pf_in          = '0;
                     pf_in[PF_ZERO] = pf_ff[PF_ZERO];
                     pv_in          = '0;
                  end else begin
                     if (pf_ff[PF_FIRST]) begin
                        pf_in[PF_ZERO] = !pf_ff[PF_NONEMPTY] && (b == CH_0);
                     end
                     pf_in[PF_NONEMPTY] = 1'b1;
                     if (is_digit) begin
                        pv_in = (pv_acc > {4'd0, PV_MAX}) ? PV_MAX : pv_acc[BYTE_W-1:0];
                     end else begin
                        pf_in[PF_BAD] = 1'b1;
                     end
                  end
               end
            end
            default: begin
               mode_in   = M_IDLE;
               idle_byte = 1'b1;
            end
         endcase
      end

      // byte seen with no sequence open
      if (idle_byte) begin
         if (b == CH_ESC) begin
            cmd.store_en  = 1'b1;
            cmd.store_idx = '0;
            cnt_in        = SEQ_CNT_W'(1);
            mode_in       = M_ESC;
         end else begin
            cmd.lit_en = 1'b1;
         end
      end

      // chunk end spills whatever is still open
      if (req_data.chunk_end && mode_in != M_IDLE) begin
         cmd.post_count = cnt_in;
         mode_in        = M_IDLE;
         cnt_in         = '0;
         pv_in          = '0;
         pf_in          = '0;
      end
   end

   assign q_cmd  = cmd;
   assign q_push = acc && (cmd.store_en || cmd.lit_en ||
                           cmd.pre_count != '0 || cmd.post_count != '0);

   // configuration writes
   always_comb begin
      en_in  = en_ff;
      dfg_in = dfg_ff;
      dbg_in = dbg_ff;
      if (csr_we) begin
         case (csr_idx)
            CSR_PARSE_ENABLE: en_in  = csr_wdata[0];
            CSR_DEFAULT_FG:   dfg_in = csr_wdata;
            CSR_DEFAULT_BG:   dbg_in = csr_wdata;
            default:          en_in  = en_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      en_ff  <= en_in;
      dfg_ff <= dfg_in;
      dbg_ff <= dbg_in;
      if (acc) begin
         mode_ff   <= mode_in;
         cnt_ff    <= cnt_in;
         pv_ff     <= pv_in;
         pf_ff     <= pf_in;
         shadow_ff <= shadow_in;
         cur_ff    <= cur_in;
      end
      if (reset) begin
         en_ff          <= 1'b0;
         dfg_ff         <= RESET_FG;
         dbg_ff         <= RESET_BG;
         mode_ff        <= M_IDLE;
         cnt_ff         <= '0;
         pv_ff          <= '0;
         pf_ff          <= '0;
         shadow_ff.fg   <= RESET_FG;
         shadow_ff.bg   <= RESET_BG;
         shadow_ff.bold <= 1'b0;
         cur_ff.fg      <= RESET_FG;
         cur_ff.bg      <= RESET_BG;
         cur_ff.bold    <= 1'b0;
      end
   end

endmodule

/* src/asgr_queue.sv */
`timescale 1ns / 1ps

module asgr_queue import asgr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    q_valid,
   output logic    q_full,
   output cmd_type q_head
);

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   fill_ff, fill_in;

   assign q_valid = (fill_ff != '0);
   assign q_full  = (fill_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign q_head  = slot_ff[rd_ptr_ff];

   // pointer and fill update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      wr_ptr_ff <= wr_ptr_in;
      rd_ptr_ff <= rd_ptr_in;
      fill_ff   <= fill_in;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end
   end

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |-> !q_full)
      else $error("command queue overflow");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_valid)
      else $error("command queue underflow");

   a_fill_tracks_ptrs: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0 || q_full) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue fill count out of step with pointers");
`endif

endmodule

/* src/asgr_back.sv */
`timescale 1ns / 1ps

module asgr_back import asgr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   input  cmd_type q_head,
   output logic    q_pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   typedef enum logic [1:0] {
      B_IDLE = 2'd0,
      B_PRE  = 2'd1,
      B_LIT  = 2'd2,
      B_POST = 2'd3
   } state_type;

   // sequence buffer
   logic [BYTE_W-1:0] mem_ff [MAX_SEQ];
   logic [BYTE_W-1:0] mem_q_ff;
   logic              mem_we;
   logic              mem_rd;
   logic [SEQ_IDX_W-1:0] rd_addr;

   state_type            state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [SEQ_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 rd_pend_ff, rd_pend_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                 out_free;
   logic [SEQ_CNT_W-1:0] cnt_next;
   logic [SEQ_CNT_W-1:0] flush_len;
   logic                 flush_last;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign cnt_next  = cnt_ff + SEQ_CNT_W'(1);
   assign rd_addr   = cnt_ff[SEQ_IDX_W-1:0];
   assign flush_len = (state_ff == B_PRE) ? cmd_ff.pre_count : cmd_ff.post_count;
   assign flush_last = (state_ff == B_PRE) ?
                       (cnt_next == cmd_ff.pre_count && !cmd_ff.lit_en &&
                        cmd_ff.post_count == '0) :
                       (cnt_next == cmd_ff.post_count);

   // command sequencer
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      cnt_in       = cnt_ff;
      rd_pend_in   = rd_pend_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      mem_rd       = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               if (q_head.pre_count == '0 && q_head.post_count == '0) begin
                  // plain literal or buffer write: handled without leaving the idle state
                  if (!q_head.lit_en || out_free) begin
                     q_pop  = 1'b1;
                     mem_we = q_head.store_en;
                     if (q_head.lit_en) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = {q_head.data_byte, q_head.attr.fg, q_head.attr.bg,
                                        q_head.attr.bold, 1'b1};
                     end
                  end
               end else begin
                  q_pop    = 1'b1;
                  mem_we   = q_head.store_en;
                  cmd_in   = q_head;
                  cnt_in   = '0;
                  state_in = B_PRE;
               end
            end
         end
         B_LIT: begin
            if (!cmd_ff.lit_en) begin
               state_in = B_POST;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {cmd_ff.data_byte, cmd_ff.attr.fg, cmd_ff.attr.bg,
                               cmd_ff.attr.bold, cmd_ff.post_count == '0};
               state_in     = B_POST;
            end
         end
         B_PRE, B_POST: begin
            if (cnt_ff == flush_len) begin
               cnt_in   = '0;
               state_in = (state_ff == B_PRE) ? B_LIT : B_IDLE;
            end else if (rd_pend_ff) begin
               // buffered byte already read into mem_q_ff
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = {mem_q_ff, cmd_ff.attr.fg, cmd_ff.attr.bg,
                                  cmd_ff.attr.bold, flush_last};
                  cnt_in       = cnt_next;
                  rd_pend_in   = 1'b0;
               end
            end else begin
               mem_rd     = 1'b1;
               rd_pend_in = 1'b1;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   // buffer write and registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[q_head.store_idx] <= q_head.data_byte;
      end
      if (mem_rd) begin
         mem_q_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      state_ff     <= state_in;
      cmd_ff       <= cmd_in;
      cnt_ff       <= cnt_in;
      rd_pend_ff   <= rd_pend_in;
      rsp_valid_ff <= rsp_valid_in;
      rsp_data_ff  <= rsp_data_in;
      if (reset) begin
         state_ff     <= B_IDLE;
         cnt_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_read_only_in_flush: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> (state_ff == B_PRE || state_ff == B_POST))
      else $error("buffer read outstanding outside a flush");

   a_pre_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_PRE) |-> (cnt_ff <= cmd_ff.pre_count))
      else $error("flush ran past its length");

   a_post_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_POST) |-> (cnt_ff <= cmd_ff.post_count))
      else $error("chunk-end flush ran past its length");

   a_no_pop_when_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != B_IDLE) |-> !q_pop)
      else $error("command taken while another is in progress");
`endif

endmodule

/* src/ansi_sgr_color_parser_core.sv */
// a literal beat passes through a queue slot and then the output register before it is presented
// throughput: one literal byte per cycle while the output is not stalled; a spilling command
//   leaves the queue, moves each buffered byte through a buffer read and the output register,
//   closes its two flush phases and passes its literal slot; input stalls once 4 commands wait
// reset: synchronous, active high; clears parser state, queue and output, restores
//   registers and attributes to defaults; the sequence buffer is not cleared
`timescale 1ns / 1ps

module ansi_sgr_color_parser_core import asgr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_idx,
   input  logic [RGB_W-1:0]     csr_wdata
);

   logic    q_push;
   cmd_type q_cmd;
   logic    q_pop;
   logic    q_valid;
   logic    q_full;
   cmd_type q_head;

   // parser: classifies bytes and tracks attributes
   asgr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cmd     (q_cmd)
   );

   // command queue
   asgr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .pop      (q_pop),
      .q_valid  (q_valid),
      .q_full   (q_full),
      .q_head   (q_head)
   );

   // emitter: owns the sequence buffer and output register
   asgr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* verif/tb_ansi_sgr_color_parser_core.sv */
`timescale 1ns / 1ps

import asgr_pkg::*;

// parser modes of the tracker
typedef enum logic [1:0] {
   SEQ_IDLE = 2'd0,
   SEQ_ESC  = 2'd1,
   SEQ_CSI  = 2'd2
} seq_mode_type;

// parameter flags
localparam logic [3:0] PF_NONEMPTY = 4'b0001;
localparam logic [3:0] PF_BAD      = 4'b0010;
localparam logic [3:0] PF_ZERO     = 4'b0100;
localparam logic [3:0] PF_FIRST    = 4'b1000;

// characters the parser cares about
localparam logic [7:0] CH_ESC     = 8'h1B;
localparam logic [7:0] CH_LB      = "[";
localparam logic [7:0] CH_SEMI    = ";";
localparam logic [7:0] CH_M       = "m";
localparam logic [7:0] CH_0       = "0";
localparam logic [7:0] CH_9       = "9";
localparam logic [7:0] CH_UPPER_A = "A";
localparam logic [7:0] CH_UPPER_Z = "Z";
localparam logic [7:0] CH_LOWER_A = "a";
localparam logic [7:0] CH_LOWER_Z = "z";

// sgr codes
localparam int SGR_BOLD     = 1;
localparam int SGR_NORMAL   = 22;
localparam int SGR_FG_LO    = 30;
localparam int SGR_FG_HI    = 37;
localparam int SGR_BG_LO    = 40;
localparam int SGR_BG_HI    = 47;
localparam int SGR_FG_BR_LO = 90;
localparam int SGR_FG_BR_HI = 97;
localparam int SGR_BG_BR_LO = 100;
localparam int SGR_BG_BR_HI = 107;

// tracks terminal attributes and holds the styled bytes still due
class styled_text_board;
   bit           parse_on;
   logic [23:0]  dflt_fg, dflt_bg;
   seq_mode_type mode;
   logic [7:0]   seq_buf [MAX_SEQ];
   int           seq_len;
   int           pval;
   logic [3:0]   pflags;
   logic [23:0]  sh_fg, sh_bg, cur_fg, cur_bg;
   logic         sh_bold, cur_bold;
   rsp_type      glyphs_due [$];
   rsp_type      step_glyphs [$];
   int           error_count;

   function new();
      parse_on = 1'b0;
      dflt_fg = RESET_FG;
      dflt_bg = RESET_BG;
      mode = SEQ_IDLE;
      seq_len = 0;
      pval = 0;
      pflags = '0;
      sh_fg = RESET_FG;
      cur_fg = RESET_FG;
      sh_bg = RESET_BG;
      cur_bg = RESET_BG;
      sh_bold = 1'b0;
      cur_bold = 1'b0;
      error_count = 0;
   endfunction

   function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [RGB_W-1:0] value);
      case (idx)
         CSR_PARSE_ENABLE: parse_on = value[0];
         CSR_DEFAULT_FG:   dflt_fg = value;
         CSR_DEFAULT_BG:   dflt_bg = value;
         default: ;
      endcase
   endfunction

   function logic [23:0] palette(int idx);
      case (idx)
         0:  return 24'h000000;
         1:  return 24'hAA0000;
         2:  return 24'h00AA00;
         3:  return 24'hAA5500;
         4:  return 24'h0000AA;
         5:  return 24'hAA00AA;
         6:  return 24'h00AAAA;
         7:  return 24'hAAAAAA;
         8:  return 24'h555555;
         9:  return 24'hFF5555;
         10: return 24'h55FF55;
         11: return 24'hFFFF55;
         12: return 24'h5555FF;
         13: return 24'hFF55FF;
         14: return 24'h55FFFF;
         default: return 24'hFFFFFF;
      endcase
   endfunction

   // one literal byte with the attributes in force now
   function void put_glyph(logic [7:0] b);
      rsp_type g;
      g.out_byte = b;
      g.fg_rgb = cur_fg;
      g.bg_rgb = cur_bg;
      g.bold_on = cur_bold;
      g.last_of_run = 1'b0;
      step_glyphs.push_back(g);
   endfunction

   // unfinished sequence goes out as text
   function void spill();
      for (int i = 0; i < seq_len; i++)
         put_glyph(seq_buf[i]);
      seq_len = 0;
      mode = SEQ_IDLE;
      pval = 0;
      pflags = '0;
   endfunction

   function void idle_byte(logic [7:0] b);
      if (b == CH_ESC) begin
         seq_buf[0] = b;
         seq_len = 1;
         mode = SEQ_ESC;
      end else begin
         put_glyph(b);
      end
   endfunction

   function void apply_code(int code);
      if (code == SGR_BOLD)
         sh_bold = 1'b1;
      else if (code == SGR_NORMAL)
         sh_bold = 1'b0;
      else if (code >= SGR_FG_LO && code <= SGR_FG_HI)
         sh_fg = palette(code - SGR_FG_LO);
      else if (code >= SGR_BG_LO && code <= SGR_BG_HI)
         sh_bg = palette(code - SGR_BG_LO);
      else if (code >= SGR_FG_BR_LO && code <= SGR_FG_BR_HI)
         sh_fg = palette(code - SGR_FG_BR_LO + 8);
      else if (code >= SGR_BG_BR_LO && code <= SGR_BG_BR_HI)
         sh_bg = palette(code - SGR_BG_BR_LO + 8);
   endfunction

   function void close_param();
      bit ok;
      ok = ((pflags & PF_NONEMPTY) != 0) && ((pflags & PF_BAD) == 0);
      if ((pflags & PF_ZERO) == 0 && ok)
         apply_code(pval);
      pflags = pflags & PF_ZERO;
      pval = 0;
   endfunction

   function bit is_letter(logic [7:0] b);
      return (b >= CH_UPPER_A && b <= CH_UPPER_Z) || (b >= CH_LOWER_A && b <= CH_LOWER_Z);
   endfunction

   // accepted input beat: advance the parser and queue what it displays
   function void take_byte(req_type item);
      logic [7:0] b;
      rsp_type    g;
      b = item.in_byte;
      step_glyphs.delete();
      if (!parse_on) begin
         spill();
         put_glyph(b);
      end else begin
         case (mode)
            SEQ_ESC: begin
               if (b == CH_LB && seq_len < MAX_SEQ) begin
                  seq_buf[seq_len] = b;
                  seq_len++;
                  mode = SEQ_CSI;
                  sh_fg = cur_fg;
                  sh_bg = cur_bg;
                  sh_bold = cur_bold;
                  pval = 0;
                  pflags = PF_FIRST;
               end else begin
                  spill();
                  idle_byte(b);
               end
            end
            SEQ_CSI: begin
               if (is_letter(b)) begin
                  close_param();
                  if (b == CH_M) begin
                     if ((pflags & PF_ZERO) != 0) begin
                        cur_fg = dflt_fg;
                        cur_bg = dflt_bg;
                        cur_bold = 1'b0;
                     end else begin
                        cur_fg = sh_fg;
                        cur_bg = sh_bg;
                        cur_bold = sh_bold;
                     end
                  end
                  mode = SEQ_IDLE;
                  seq_len = 0;
                  pval = 0;
                  pflags = '0;
               end else if (seq_len >= MAX_SEQ) begin
                  spill();
                  idle_byte(b);
               end else begin
                  seq_buf[seq_len] = b;
                  seq_len++;
                  if (b == CH_SEMI) begin
                     close_param();
                  end else begin
                     // a first parameter of exactly one zero means reset
                     if ((pflags & PF_FIRST) != 0) begin
                        if ((pflags & PF_NONEMPTY) == 0 && b == CH_0)
                           pflags = pflags | PF_ZERO;
                        else
                           pflags = pflags & ~PF_ZERO;
                     end
                     pflags = pflags | PF_NONEMPTY;
                     if (b >= CH_0 && b <= CH_9) begin
                        pval = pval * 10 + (int'(b) - int'(CH_0));
                        if (pval > 255)
                           pval = 255;
                     end else begin
                        pflags = pflags | PF_BAD;
                     end
                  end
               end
            end
            default: begin
               mode = SEQ_IDLE;
               idle_byte(b);
            end
         endcase
      end
      if (item.chunk_end && mode != SEQ_IDLE)
         spill();
      if (step_glyphs.size() > 0) begin
         g = step_glyphs.pop_back();
         g.last_of_run = 1'b1;
         step_glyphs.push_back(g);
      end
      foreach (step_glyphs[i])
         glyphs_due.push_back(step_glyphs[i]);
   endfunction

   task report(string what, logic [31:0] got, logic [31:0] want);
      if (error_count < 40)
         $display("styled byte error: %s got %0h want %0h", what, got, want);
      error_count++;
   endtask

   // accepted output beat against the oldest styled byte due
   task check_glyph(rsp_type got);
      rsp_type want;
      if (glyphs_due.size() == 0) begin
         report("beat with nothing due, out_byte", got.out_byte, 0);
      end else begin
         want = glyphs_due.pop_front();
         if (got.out_byte !== want.out_byte)
            report("out_byte", got.out_byte, want.out_byte);
         if (got.fg_rgb !== want.fg_rgb)
            report("fg_rgb", got.fg_rgb, want.fg_rgb);
         if (got.bg_rgb !== want.bg_rgb)
            report("bg_rgb", got.bg_rgb, want.bg_rgb);
         if (got.bold_on !== want.bold_on)
            report("bold_on", got.bold_on, want.bold_on);
         if (got.last_of_run !== want.last_of_run)
            report("last_of_run", got.last_of_run, want.last_of_run);
      end
   endtask
endclass

module tb_ansi_sgr_color_parser_core;

   localparam int CHUNK_END_PCT = 5;
   localparam int SEG_ITEMS     = 60;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_idx   = '0;
   logic [RGB_W-1:0]     csr_wdata = '0;

   styled_text_board board;
   int               tx_idle_pct = 0;
   int               rx_idle_pct = 0;
   int               bytes_sent  = 0;

   ansi_sgr_color_parser_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rx_idle_pct);
   end

   // output beats
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_glyph(rsp_data);
   end

   // one input beat, entered and left at a falling edge
   task send_byte(logic [7:0] b, logic ce);
      req_type item;
      item.in_byte = b;
      item.chunk_end = ce;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      board.take_byte(item);
      bytes_sent++;
      @(negedge clock);
   endtask

   task send_text(logic [7:0] b);
      send_byte(b, $urandom_range(99) < CHUNK_END_PCT);
   endtask

   task send_seq(string s, logic ce_last);
      for (int k = 0; k < s.len(); k++)
         send_byte(s[k], ce_last && (k == s.len() - 1));
   endtask

   // wait for every styled byte, then let the parser settle
   task wait_quiet();
      req_valid <= 1'b0;
      while (board.glyphs_due.size() != 0)
         @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task write_reg(logic [CSR_IDX_W-1:0] idx, logic [RGB_W-1:0] value);
      csr_we <= 1'b1;
      csr_idx <= idx;
      csr_wdata <= value;
      board.set_reg(idx, value);
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // csi with random, sometimes malformed parameters and usually an m final
   task send_sgr();
      int         n, kind, code, i, k;
      string      digits, junk;
      logic [7:0] fin;
      junk = "+- ?:";
      send_text(CH_ESC);
      send_text(CH_LB);
      n = $urandom_range(1, 4);
      for (i = 0; i < n; i++) begin
         if (i > 0)
            send_text(CH_SEMI);
         kind = $urandom_range(9);
         code = -1;
         case (kind)
            0: code = -1;
            1: code = 0;
            2: code = $urandom_range(1) ? SGR_BOLD : SGR_NORMAL;
            3: code = $urandom_range(SGR_FG_HI, SGR_FG_LO);
            4: code = $urandom_range(SGR_BG_HI, SGR_BG_LO);
            5: code = $urandom_range(SGR_FG_BR_HI, SGR_FG_BR_LO);
            6: code = $urandom_range(SGR_BG_BR_HI, SGR_BG_BR_LO);
            7: code = $urandom_range(255);
            8: code = $urandom_range(999, 256);
            default: begin
               send_text(junk[$urandom_range(4)]);
               code = $urandom_range(107);
            end
         endcase
         if (code >= 0) begin
            digits = $sformatf("%0d", code);
            for (k = 0; k < digits.len(); k++)
               send_text(digits[k]);
         end
      end
      if ($urandom_range(99) < 85)
         fin = CH_M;
      else if ($urandom_range(1))
         fin = 8'(CH_UPPER_A + $urandom_range(25));
      else
         fin = 8'(CH_LOWER_A + $urandom_range(25));
      send_text(fin);
   endtask

   // mostly styled text, some overlong and broken sequences and raw noise
   task random_segment(int n_items);
      int start, r, n, i;
      start = bytes_sent;
      while (bytes_sent - start < n_items) begin
         r = $urandom_range(99);
         if (r < 60) begin
            send_sgr();
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++)
               send_text(8'($urandom_range(8'h7E, 8'h20)));
         end else if (r < 70) begin
            // fills or runs past the sequence buffer
            send_text(CH_ESC);
            send_text(CH_LB);
            n = $urandom_range(30, 40);
            for (i = 0; i < n; i++)
               send_text(8'($urandom_range(3) == 0 ? CH_SEMI : CH_0 + $urandom_range(9)));
         end else if (r < 80) begin
            case ($urandom_range(2))
               0: begin
                  send_text(CH_ESC);
                  send_text(8'($urandom_range(255)));
               end
               1: begin
                  send_text(CH_ESC);
                  send_text(CH_LB);
                  n = $urandom_range(1, 5);
                  for (i = 0; i < n; i++)
                     send_text(8'($urandom_range(255)));
               end
               default: begin
                  send_text(CH_ESC);
                  send_text(CH_ESC);
               end
            endcase
         end else begin
            n = $urandom_range(1, 8);
            for (i = 0; i < n; i++)
               send_text(8'($urandom_range(7) == 0 ? CH_ESC : $urandom_range(255)));
         end
      end
      // leave a sequence open across the next register change
      send_byte(CH_ESC, 1'b0);
      send_byte(CH_LB, 1'b0);
   endtask

   // run limit
   initial begin
      #4_800_000;
      $display("ansi_sgr_color_parser_core: mismatch");
      $finish;
   end

   initial begin
      logic [RGB_W-1:0] fg, bg;
      board = new();
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: pass-through at reset settings, then parsing with reset defaults
      tx_idle_pct = 32;
      rx_idle_pct = 55;
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      wait_quiet();
      write_reg(CSR_PARSE_ENABLE, 24'd1);
      send_seq("\033[1;97m", 1'b0);
      send_seq("\033q", 1'b0);
      send_seq("\033[0;41m", 1'b0);
      send_seq("r", 1'b0);
      send_seq("\033[300;42;-m", 1'b0);
      send_seq("\033[2J", 1'b0);
      send_seq("\033[5", 1'b1);

      // random segments across idling patterns and register settings
      for (int seg = 0; seg < 6; seg++) begin
         if (seg < 2) begin
            tx_idle_pct = 32;
            rx_idle_pct = 55;
         end else if (seg < 4) begin
            tx_idle_pct = 55;
            rx_idle_pct = 32;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         fg = (seg == 0) ? 24'h000000 : (seg == 1) ? 24'hFFFFFF : RGB_W'($urandom);
         bg = (seg == 0) ? 24'hFFFFFF : (seg == 1) ? 24'h000000 : RGB_W'($urandom);
         wait_quiet();
         write_reg(CSR_PARSE_ENABLE, (seg == 2) ? 24'd0 : 24'd1);
         write_reg(CSR_DEFAULT_FG, fg);
         write_reg(CSR_DEFAULT_BG, bg);
         random_segment(SEG_ITEMS);
      end

      wait_quiet();
      if (board.error_count == 0 && board.glyphs_due.size() == 0)
         $display("ansi_sgr_color_parser_core: match");
      else
         $display("ansi_sgr_color_parser_core: mismatch");
      $finish;
   end

endmodule

/* files.f */
src/asgr_pkg.sv
src/asgr_front.sv
src/asgr_queue.sv
src/asgr_back.sv
src/ansi_sgr_color_parser_core.sv
verif/tb_ansi_sgr_color_parser_core.sv
